FILE: rtl/sqgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqgb_pkg: shared types and constants of the single-qubit gate butterfly
// Gate codes, register indexes, register widths and reset values, and the
// fixed-point constant used by the Hadamard path.
// ----------------------------------------------------------------------------
package sqgb_pkg;

	// register widths on the configuration port
	localparam int CFG_DATA_W = 16;
	localparam int TARGET_W   = 5;
	localparam int KIND_W     = 3;
	localparam int PHASE_W    = 16;
	localparam int CFG_IDX_W  = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_QUBIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GATE_KIND    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_REAL   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_IMAG   = 2'd3;

	// gate codes, the two unused codes act as identity
	typedef enum logic [KIND_W-1:0] {
		GATE_ID    = 3'd0,
		GATE_X     = 3'd1,
		GATE_Y     = 3'd2,
		GATE_Z     = 3'd3,
		GATE_H     = 3'd4,
		GATE_PHASE = 3'd5
	} gate_kind_t;

	// reset values
	localparam logic [TARGET_W-1:0]       TARGET_RST     = '0;
	localparam logic [KIND_W-1:0]         KIND_RST       = GATE_ID;
	localparam logic signed [PHASE_W-1:0] PHASE_REAL_RST = 16'sd32767;
	localparam logic signed [PHASE_W-1:0] PHASE_IMAG_RST = 16'sd0;

	// 1/sqrt(2) in Q2.30
	localparam int INV_SQRT2_W = 32;
	localparam logic signed [INV_SQRT2_W-1:0] INV_SQRT2_Q30 = 32'sd759250125;
	localparam int INV_SQRT2_FRAC = 30;
	localparam int PHASE_FRAC     = 15;

	// gate selection handed to the arithmetic datapath
	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [PHASE_W-1:0] phase_re;
		logic signed [PHASE_W-1:0] phase_im;
	} gate_cfg_t;

endpackage

FILE: rtl/sqgb_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqgb_index: state index builder
// Inserts a 0 and a 1 bit at the target position of the pair number to form
// the two full state indices. The target is clamped to the top qubit.
// ----------------------------------------------------------------------------
module sqgb_index #(
	parameter int NUM_QUBITS = 20
) (
	input  logic [sqgb_pkg::TARGET_W-1:0]                      target_qubit,
	input  logic [((NUM_QUBITS > 1) ? NUM_QUBITS-1 : 1)-1:0]   pair_number,
	output logic [NUM_QUBITS-1:0]                               zero_index,
	output logic [NUM_QUBITS-1:0]                               one_index
);
	import sqgb_pkg::*;

	localparam int SH_W = TARGET_W + 1;
	localparam logic [SH_W-1:0] TGT_MAX = SH_W'(NUM_QUBITS - 1);

	logic [SH_W-1:0]       tgt;
	logic [NUM_QUBITS-1:0] pn_ext;
	logic [NUM_QUBITS-1:0] keep_low;
	logic [NUM_QUBITS-1:0] tgt_bit;

	// clamp target to the top qubit
	always_comb begin
		if ({1'b0, target_qubit} > TGT_MAX) begin
			tgt = TGT_MAX;
		end else begin
			tgt = {1'b0, target_qubit};
		end
	end

	// split at the target, shift the upper part up by one
	assign pn_ext     = NUM_QUBITS'(pair_number);
	assign tgt_bit    = NUM_QUBITS'(1) << tgt;
	assign keep_low   = tgt_bit - NUM_QUBITS'(1);
	assign zero_index = ((pn_ext & ~keep_low) << 1) | (pn_ext & keep_low);
	assign one_index  = zero_index | tgt_bit;

endmodule

FILE: rtl/sqgb_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqgb_arith: amplitude datapath
// Applies the selected gate to one amplitude pair: swap, multiply by +-i,
// negate, scaled sum and difference, or complex phase product. Products are
// rounded half up and every result saturates to the amplitude range.
// ----------------------------------------------------------------------------
module sqgb_arith #(
	parameter int AMP_BITS = 16
) (
	input  sqgb_pkg::gate_cfg_t         gate_cfg,
	input  logic signed [AMP_BITS-1:0]  a0_re,
	input  logic signed [AMP_BITS-1:0]  a0_im,
	input  logic signed [AMP_BITS-1:0]  a1_re,
	input  logic signed [AMP_BITS-1:0]  a1_im,
	output logic signed [AMP_BITS-1:0]  n0_re,
	output logic signed [AMP_BITS-1:0]  n0_im,
	output logic signed [AMP_BITS-1:0]  n1_re,
	output logic signed [AMP_BITS-1:0]  n1_im
);
	import sqgb_pkg::*;

	// common width ahead of saturation
	localparam int WIDE_W = AMP_BITS + 2;
	// hadamard: (AMP_BITS+1) sum times 32 bit constant
	localparam int H_PROD_W = AMP_BITS + 1 + INV_SQRT2_W;
	// phase: AMP_BITS times 16 bit, plus one bit for the sum
	localparam int P_PROD_W = AMP_BITS + PHASE_W;
	localparam int P_SUM_W  = P_PROD_W + 1;

	localparam logic signed [WIDE_W-1:0] AMP_MAX = {3'b000, {(AMP_BITS-1){1'b1}}};
	localparam logic signed [WIDE_W-1:0] AMP_MIN = {3'b111, {(AMP_BITS-1){1'b0}}};
	localparam logic signed [H_PROD_W-1:0] H_ROUND =
		{{(H_PROD_W-INV_SQRT2_FRAC){1'b0}}, 1'b1, {(INV_SQRT2_FRAC-1){1'b0}}};
	localparam logic signed [P_SUM_W-1:0] P_ROUND =
		{{(P_SUM_W-PHASE_FRAC){1'b0}}, 1'b1, {(PHASE_FRAC-1){1'b0}}};

	function automatic logic signed [AMP_BITS-1:0] sat_amp(
		input logic signed [WIDE_W-1:0] v
	);
		logic signed [AMP_BITS-1:0] r;
		if (v > AMP_MAX) begin
			r = AMP_MAX[AMP_BITS-1:0];
		end else if (v < AMP_MIN) begin
			r = AMP_MIN[AMP_BITS-1:0];
		end else begin
			r = v[AMP_BITS-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [WIDE_W-1:0] widen(
		input logic signed [AMP_BITS-1:0] v
	);
		return {{2{v[AMP_BITS-1]}}, v};
	endfunction

	// hadamard scaling of one sum or difference, round half up
	function automatic logic signed [WIDE_W-1:0] h_scale(
		input logic signed [AMP_BITS:0] s
	);
		logic signed [H_PROD_W-1:0] prod;
		logic signed [H_PROD_W-1:0] rnd;
		prod = $signed(H_PROD_W'(s)) * $signed(H_PROD_W'(INV_SQRT2_Q30));
		rnd  = prod + H_ROUND;
		return $signed(rnd[WIDE_W-1+INV_SQRT2_FRAC:INV_SQRT2_FRAC]);
	endfunction

	logic signed [AMP_BITS:0]   h_sum_re, h_sum_im, h_dif_re, h_dif_im;
	logic signed [WIDE_W-1:0]   h0_re, h0_im, h1_re, h1_im;
	logic signed [P_PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
	logic signed [P_SUM_W-1:0]  p_re_sum, p_im_sum;
	logic signed [WIDE_W-1:0]   ph_re, ph_im;
	logic signed [WIDE_W-1:0]   w0_re, w0_im, w1_re, w1_im;

	// hadamard sum and difference, exact
	assign h_sum_re = $signed({a0_re[AMP_BITS-1], a0_re}) + $signed({a1_re[AMP_BITS-1], a1_re});
	assign h_sum_im = $signed({a0_im[AMP_BITS-1], a0_im}) + $signed({a1_im[AMP_BITS-1], a1_im});
	assign h_dif_re = $signed({a0_re[AMP_BITS-1], a0_re}) - $signed({a1_re[AMP_BITS-1], a1_re});
	assign h_dif_im = $signed({a0_im[AMP_BITS-1], a0_im}) - $signed({a1_im[AMP_BITS-1], a1_im});
	assign h0_re = h_scale(h_sum_re);
	assign h0_im = h_scale(h_sum_im);
	assign h1_re = h_scale(h_dif_re);
	assign h1_im = h_scale(h_dif_im);

	// complex product of the second amplitude and the phase
	assign p_rr = $signed(P_PROD_W'(a1_re)) * $signed(P_PROD_W'(gate_cfg.phase_re));
	assign p_ii = $signed(P_PROD_W'(a1_im)) * $signed(P_PROD_W'(gate_cfg.phase_im));
	assign p_ri = $signed(P_PROD_W'(a1_re)) * $signed(P_PROD_W'(gate_cfg.phase_im));
	assign p_ir = $signed(P_PROD_W'(a1_im)) * $signed(P_PROD_W'(gate_cfg.phase_re));
	assign p_re_sum = $signed({p_rr[P_PROD_W-1], p_rr}) - $signed({p_ii[P_PROD_W-1], p_ii})
		+ P_ROUND;
	assign p_im_sum = $signed({p_ri[P_PROD_W-1], p_ri}) + $signed({p_ir[P_PROD_W-1], p_ir})
		+ P_ROUND;
	assign ph_re = $signed(p_re_sum[WIDE_W-1+PHASE_FRAC:PHASE_FRAC]);
	assign ph_im = $signed(p_im_sum[WIDE_W-1+PHASE_FRAC:PHASE_FRAC]);

	// gate select, negations are done wide and saturate later
	always_comb begin
		w0_re = widen(a0_re);
		w0_im = widen(a0_im);
		w1_re = widen(a1_re);
		w1_im = widen(a1_im);
		unique case (gate_cfg.kind)
			GATE_X: begin
				w0_re = widen(a1_re);
				w0_im = widen(a1_im);
				w1_re = widen(a0_re);
				w1_im = widen(a0_im);
			end
			GATE_Y: begin
				w0_re = -widen(a1_im);
				w0_im = widen(a1_re);
				w1_re = widen(a0_im);
				w1_im = -widen(a0_re);
			end
			GATE_Z: begin
				w1_re = -widen(a1_re);
				w1_im = -widen(a1_im);
			end
			GATE_H: begin
				w0_re = h0_re;
				w0_im = h0_im;
				w1_re = h1_re;
				w1_im = h1_im;
			end
			GATE_PHASE: begin
				w1_re = ph_re;
				w1_im = ph_im;
			end
			default: begin
			end
		endcase
	end

	// saturate to the amplitude range
	assign n0_re = sat_amp(w0_re);
	assign n0_im = sat_amp(w0_im);
	assign n1_re = sat_amp(w1_re);
	assign n1_im = sat_amp(w1_im);

endmodule

FILE: rtl/single_qubit_gate_butterfly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_qubit_gate_butterfly: state-vector single-qubit gate
// Applies identity, X, Y, Z, Hadamard or a phase gate to one amplitude pair
// and forms the two state indices of the pair.
//
//   port group        | direction | handshake
//   ------------------+-----------+------------------------------------------
//   input word        | in        | start, taken when busy is low
//   result word       | out       | done, valid for one cycle only
//   config write      | in        | cfg_we, cfg_index, cfg_data
//
// One word is taken every cycle; busy never rises. Each taken word passes
// one input register, then the index and gate datapath (one multiplier
// deep) into the result register.
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver has no stall; done marks each result for one cycle.
// ----------------------------------------------------------------------------
module single_qubit_gate_butterfly #(
	parameter int NUM_QUBITS = 20,
	parameter int AMP_BITS   = 16
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	// configuration
	input  logic                                              cfg_we,
	input  logic [sqgb_pkg::CFG_IDX_W-1:0]                    cfg_index,
	input  logic [sqgb_pkg::CFG_DATA_W-1:0]                   cfg_data,
	// input word
	input  logic                                              start,
	output logic                                              busy,
	input  logic [((NUM_QUBITS > 1) ? NUM_QUBITS-1 : 1)-1:0]  pair_number,
	input  logic signed [AMP_BITS-1:0]                        zero_real,
	input  logic signed [AMP_BITS-1:0]                        zero_imag,
	input  logic signed [AMP_BITS-1:0]                        one_real,
	input  logic signed [AMP_BITS-1:0]                        one_imag,
	// result word
	output logic                                              done,
	output logic [NUM_QUBITS-1:0]                             zero_index,
	output logic [NUM_QUBITS-1:0]                             one_index,
	output logic signed [AMP_BITS-1:0]                        new_zero_real,
	output logic signed [AMP_BITS-1:0]                        new_zero_imag,
	output logic signed [AMP_BITS-1:0]                        new_one_real,
	output logic signed [AMP_BITS-1:0]                        new_one_imag
);
	import sqgb_pkg::*;

	localparam int PN_W = (NUM_QUBITS > 1) ? NUM_QUBITS - 1 : 1;

	logic [TARGET_W-1:0]       target_q;
	logic [KIND_W-1:0]         kind_q;
	logic signed [PHASE_W-1:0] phase_re_q;
	logic signed [PHASE_W-1:0] phase_im_q;
	gate_cfg_t                 gate_cfg;

	logic                       valid_s1;
	logic [PN_W-1:0]            pn_s1;
	logic signed [AMP_BITS-1:0] a0_re_s1, a0_im_s1, a1_re_s1, a1_im_s1;

	logic [NUM_QUBITS-1:0]      zi_c, oi_c;
	logic signed [AMP_BITS-1:0] n0_re_c, n0_im_c, n1_re_c, n1_im_c;

	logic                       valid_s2;
	logic [NUM_QUBITS-1:0]      zi_s2, oi_s2;
	logic signed [AMP_BITS-1:0] n0_re_s2, n0_im_s2, n1_re_s2, n1_im_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= TARGET_RST;
			kind_q     <= KIND_RST;
			phase_re_q <= PHASE_REAL_RST;
			phase_im_q <= PHASE_IMAG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET_QUBIT: target_q   <= cfg_data[TARGET_W-1:0];
				CFG_GATE_KIND:    kind_q     <= cfg_data[KIND_W-1:0];
				CFG_PHASE_REAL:   phase_re_q <= $signed(cfg_data[PHASE_W-1:0]);
				CFG_PHASE_IMAG:   phase_im_q <= $signed(cfg_data[PHASE_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	assign gate_cfg.kind     = kind_q;
	assign gate_cfg.phase_re = phase_re_q;
	assign gate_cfg.phase_im = phase_im_q;

	// a word enters every cycle
	assign busy = 1'b0;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pn_s1    <= pair_number;
			a0_re_s1 <= zero_real;
			a0_im_s1 <= zero_imag;
			a1_re_s1 <= one_real;
			a1_im_s1 <= one_imag;
		end
	end

	// state indices
	sqgb_index #(
		.NUM_QUBITS (NUM_QUBITS)
	) u_index (
		.target_qubit (target_q),
		.pair_number  (pn_s1),
		.zero_index   (zi_c),
		.one_index    (oi_c)
	);

	// gate arithmetic
	sqgb_arith #(
		.AMP_BITS (AMP_BITS)
	) u_arith (
		.gate_cfg (gate_cfg),
		.a0_re    (a0_re_s1),
		.a0_im    (a0_im_s1),
		.a1_re    (a1_re_s1),
		.a1_im    (a1_im_s1),
		.n0_re    (n0_re_c),
		.n0_im    (n0_im_c),
		.n1_re    (n1_re_c),
		.n1_im    (n1_im_c)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			zi_s2    <= zi_c;
			oi_s2    <= oi_c;
			n0_re_s2 <= n0_re_c;
			n0_im_s2 <= n0_im_c;
			n1_re_s2 <= n1_re_c;
			n1_im_s2 <= n1_im_c;
		end
	end

	// result word
	assign done          = valid_s2;
	assign zero_index    = zi_s2;
	assign one_index     = oi_s2;
	assign new_zero_real = n0_re_s2;
	assign new_zero_imag = n0_im_s2;
	assign new_one_real  = n1_re_s2;
	assign new_one_imag  = n1_im_s2;

endmodule

FILE: dv/single_qubit_gate_butterfly_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_qubit_gate_butterfly_test: self-checking bench of the gate butterfly
// Drives amplitude pairs through every gate kind and a spread of target
// positions and phase factors, predicts both state indices and the updated
// amplitudes of each word, and compares every result word in order.
// ----------------------------------------------------------------------------
module single_qubit_gate_butterfly_test;
	import sqgb_pkg::*;

	localparam int NQ       = 20;
	localparam int AB       = 16;
	localparam int PAIR_W   = NQ - 1;
	localparam int IDLE_MAX = 1000;

	// spare gate codes, both behave as identity
	localparam logic [KIND_W-1:0] GATE_SPARE_A = 3'd6;
	localparam logic [KIND_W-1:0] GATE_SPARE_B = 3'd7;

	// named phase factors
	localparam logic signed [PHASE_W-1:0] Q_ONE  = 16'sd32767;
	localparam logic signed [PHASE_W-1:0] Q_MIN  = -16'sd32768;
	localparam logic signed [PHASE_W-1:0] Q_T    = 16'sd23170;

	typedef struct {
		logic [PAIR_W-1:0]    pair;
		logic signed [AB-1:0] a0_re;
		logic signed [AB-1:0] a0_im;
		logic signed [AB-1:0] a1_re;
		logic signed [AB-1:0] a1_im;
	} pair_word_t;

	typedef struct {
		logic [NQ-1:0]        zero_idx;
		logic [NQ-1:0]        one_idx;
		logic signed [AB-1:0] n0_re;
		logic signed [AB-1:0] n0_im;
		logic signed [AB-1:0] n1_re;
		logic signed [AB-1:0] n1_im;
	} gate_result_t;

	// holds the register copy and the updated pairs still to come out
	class butterfly_scoreboard;
		logic [TARGET_W-1:0]       target_qubit = TARGET_RST;
		logic [KIND_W-1:0]         gate_kind    = KIND_RST;
		logic signed [PHASE_W-1:0] phase_re     = PHASE_REAL_RST;
		logic signed [PHASE_W-1:0] phase_im     = PHASE_IMAG_RST;
		gate_result_t              updated_pairs_due[$];
		int                        errors = 0;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_TARGET_QUBIT: target_qubit = data[TARGET_W-1:0];
				CFG_GATE_KIND:    gate_kind    = data[KIND_W-1:0];
				CFG_PHASE_REAL:   phase_re     = data;
				CFG_PHASE_IMAG:   phase_im     = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return updated_pairs_due.size();
		endfunction

		static function logic signed [AB-1:0] clamp_amp(longint v);
			if (v > 32767)
				return 16'sd32767;
			if (v < -32768)
				return -16'sd32768;
			return v[AB-1:0];
		endfunction

		// add half then floor, so ties go toward plus infinity
		static function longint round_shift(longint v, int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		// index insertion and gate arithmetic for one pair
		function gate_result_t butterfly(pair_word_t w);
			int unsigned   t;
			logic [NQ-1:0] wide_pair;
			logic [NQ-1:0] one_bit;
			logic [NQ-1:0] keep_low;
			longint        r0, i0, r1, i1, pr, pi, k;
			longint        n0r, n0i, n1r, n1i;
			gate_result_t  r;
			t = (target_qubit > NQ - 1) ? NQ - 1 : target_qubit;
			wide_pair = {1'b0, w.pair};
			one_bit = NQ'(1);
			keep_low = (one_bit << t) - NQ'(1);
			r.zero_idx = ((wide_pair & ~keep_low) << 1) | (wide_pair & keep_low);
			r.one_idx = r.zero_idx | (one_bit << t);
			r0 = longint'(w.a0_re);
			i0 = longint'(w.a0_im);
			r1 = longint'(w.a1_re);
			i1 = longint'(w.a1_im);
			n0r = r0; n0i = i0; n1r = r1; n1i = i1;
			k = longint'(INV_SQRT2_Q30);
			case (gate_kind)
				GATE_X: begin
					n0r = r1; n0i = i1; n1r = r0; n1i = i0;
				end
				GATE_Y: begin
					n0r = -i1; n0i = r1; n1r = i0; n1i = -r0;
				end
				GATE_Z: begin
					n1r = -r1; n1i = -i1;
				end
				GATE_H: begin
					n0r = round_shift((r0 + r1) * k, INV_SQRT2_FRAC);
					n0i = round_shift((i0 + i1) * k, INV_SQRT2_FRAC);
					n1r = round_shift((r0 - r1) * k, INV_SQRT2_FRAC);
					n1i = round_shift((i0 - i1) * k, INV_SQRT2_FRAC);
				end
				GATE_PHASE: begin
					pr = longint'(phase_re);
					pi = longint'(phase_im);
					n1r = round_shift(r1 * pr - i1 * pi, PHASE_FRAC);
					n1i = round_shift(r1 * pi + i1 * pr, PHASE_FRAC);
				end
				default: ;
			endcase
			r.n0_re = clamp_amp(n0r);
			r.n0_im = clamp_amp(n0i);
			r.n1_re = clamp_amp(n1r);
			r.n1_im = clamp_amp(n1i);
			return r;
		endfunction

		function void note_word(pair_word_t w);
			updated_pairs_due.push_back(butterfly(w));
		endfunction

		task report_mismatch(string what, longint got, longint want);
			$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
			errors++;
		endtask

		task check_word(gate_result_t got);
			gate_result_t want;
			if (updated_pairs_due.size() == 0) begin
				report_mismatch("result word with no word outstanding", 0, 0);
				return;
			end
			want = updated_pairs_due.pop_front();
			if (got.zero_idx !== want.zero_idx)
				report_mismatch("zero_index", got.zero_idx, want.zero_idx);
			if (got.one_idx !== want.one_idx)
				report_mismatch("one_index", got.one_idx, want.one_idx);
			if (got.n0_re !== want.n0_re)
				report_mismatch("new_zero_real", got.n0_re, want.n0_re);
			if (got.n0_im !== want.n0_im)
				report_mismatch("new_zero_imag", got.n0_im, want.n0_im);
			if (got.n1_re !== want.n1_re)
				report_mismatch("new_one_real", got.n1_re, want.n1_re);
			if (got.n1_im !== want.n1_im)
				report_mismatch("new_one_imag", got.n1_im, want.n1_im);
		endtask
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_DATA_W-1:0]       cfg_data;
	logic                        start;
	logic                        busy;
	logic [PAIR_W-1:0]           pair_number;
	logic signed [AB-1:0]        zero_real;
	logic signed [AB-1:0]        zero_imag;
	logic signed [AB-1:0]        one_real;
	logic signed [AB-1:0]        one_imag;
	logic                        done;
	logic [NQ-1:0]               zero_index;
	logic [NQ-1:0]               one_index;
	logic signed [AB-1:0]        new_zero_real;
	logic signed [AB-1:0]        new_zero_imag;
	logic signed [AB-1:0]        new_one_real;
	logic signed [AB-1:0]        new_one_imag;

	butterfly_scoreboard sb = new;
	int                  idle_cycles = 0;

	single_qubit_gate_butterfly #(
		.NUM_QUBITS(NQ),
		.AMP_BITS(AB)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.pair_number(pair_number),
		.zero_real(zero_real),
		.zero_imag(zero_imag),
		.one_real(one_real),
		.one_imag(one_imag),
		.done(done),
		.zero_index(zero_index),
		.one_index(one_index),
		.new_zero_real(new_zero_real),
		.new_zero_imag(new_zero_imag),
		.new_one_real(new_one_real),
		.new_one_imag(new_one_imag)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// monitor: register writes, accepted words and result words
	always @(posedge clk) begin
		gate_result_t got;
		pair_word_t   w;
		if (arst_n) begin
			if (done) begin
				got.zero_idx = zero_index;
				got.one_idx = one_index;
				got.n0_re = new_zero_real;
				got.n0_im = new_zero_imag;
				got.n1_re = new_one_real;
				got.n1_im = new_one_imag;
				sb.check_word(got);
			end
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (start && !busy) begin
				w.pair = pair_number;
				w.a0_re = zero_real;
				w.a0_im = zero_imag;
				w.a1_re = one_real;
				w.a1_im = one_imag;
				sb.note_word(w);
			end
		end
	end

	// watchdog on cycles without any accepted word, write or result
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_MAX) begin
			$display("timeout after %0d quiet cycles", idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// present one word and hold it until taken
	task send_word(logic [PAIR_W-1:0] p, logic signed [AB-1:0] r0, logic signed [AB-1:0] i0,
			logic signed [AB-1:0] r1, logic signed [AB-1:0] i1);
		start <= 1'b1;
		pair_number <= p;
		zero_real <= r0;
		zero_imag <= i0;
		one_real <= r1;
		one_imag <= i1;
		do
			@(posedge clk);
		while (busy);
	endtask

	task idle_for(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// stop sending and wait for every outstanding result
	task drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// write all four registers once the pipe is empty
	task apply_setting(logic [TARGET_W-1:0] t, logic [KIND_W-1:0] k,
			logic signed [PHASE_W-1:0] pr, logic signed [PHASE_W-1:0] pi);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_TARGET_QUBIT;
		cfg_data <= CFG_DATA_W'(t);
		@(posedge clk);
		cfg_index <= CFG_GATE_KIND;
		cfg_data <= CFG_DATA_W'(k);
		@(posedge clk);
		cfg_index <= CFG_PHASE_REAL;
		cfg_data <= pr;
		@(posedge clk);
		cfg_index <= CFG_PHASE_IMAG;
		cfg_data <= pi;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// amplitudes lean toward the extremes and small values
	function automatic logic signed [AB-1:0] pick_amp();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 7))
			0: return 16'sd32767;
			1: return -16'sd32768;
			2: return $signed(AB'($urandom_range(0, 4))) - 16'sd2;
			default: return raw[AB-1:0];
		endcase
	endfunction

	function automatic logic [PAIR_W-1:0] pick_pair();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 9))
			0: return '1;
			1: return '0;
			default: return raw[PAIR_W-1:0];
		endcase
	endfunction

	// random setting for one phase of the random part
	task random_phase(int p);
		logic [KIND_W-1:0]         kinds[12];
		logic [TARGET_W-1:0]       t;
		logic signed [PHASE_W-1:0] pr;
		logic signed [PHASE_W-1:0] pi;
		logic [31:0]               raw;
		int                        burst_left;
		int                        gap;
		kinds = '{GATE_H, GATE_PHASE, GATE_X, GATE_Y, GATE_Z, GATE_ID, GATE_SPARE_A,
			GATE_SPARE_B, GATE_PHASE, GATE_H, GATE_PHASE, GATE_Y};
		raw = $urandom;
		case (p)
			0: t = '0;
			1: t = TARGET_W'(NQ - 1);
			2: t = '1;
			default: t = ($urandom_range(0, 3) == 0) ? TARGET_W'($urandom_range(NQ, 31))
				: TARGET_W'($urandom_range(0, NQ - 1));
		endcase
		case (p)
			1: begin pr = Q_MIN; pi = Q_MIN; end
			8: begin pr = Q_ONE; pi = Q_ONE; end
			default: begin pr = raw[15:0]; pi = raw[31:16]; end
		endcase
		apply_setting(t, kinds[p], pr, pi);
		burst_left = 0;
		for (int n = 0; n < 150; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = (p == 4 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0)
					idle_for(gap);
			end
			// one pause mid-phase until every result is back
			if (p == 6 && n == 75)
				drain();
			send_word(pick_pair(), pick_amp(), pick_amp(), pick_amp(), pick_amp());
			burst_left--;
		end
	endtask

	// stimulus
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_TARGET_QUBIT;
		cfg_data <= '0;
		start <= 1'b0;
		pair_number <= '0;
		zero_real <= '0;
		zero_imag <= '0;
		one_real <= '0;
		one_imag <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: identity at target zero
		send_word('1, Q_ONE, Q_MIN, -16'sd1, 16'sd0);
		send_word('0, Q_MIN, Q_ONE, 16'sd0, -16'sd1);
		// top target, swap
		apply_setting(TARGET_W'(NQ - 1), GATE_X, Q_ONE, 16'sd0);
		send_word('1, Q_ONE, 16'sd1, Q_MIN, 16'sd0);
		send_word(19'h40000, -16'sd5, 16'sd7, 16'sd9, -16'sd11);
		// target beyond the qubit count, Y with saturating negation
		apply_setting('1, GATE_Y, Q_ONE, 16'sd0);
		send_word('1, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_word(19'h2AAAA, 16'sd100, -16'sd200, 16'sd300, -16'sd400);
		// Z with the most negative amplitude
		apply_setting(TARGET_W'(7), GATE_Z, Q_ONE, 16'sd0);
		send_word(19'h55555, Q_ONE, Q_ONE, Q_MIN, Q_MIN);
		send_word(19'h0007F, 16'sd1, -16'sd1, Q_ONE, 16'sd0);
		// Hadamard: saturating sums and rounding
		apply_setting(TARGET_W'(10), GATE_H, Q_ONE, 16'sd0);
		send_word(19'h12345, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
		send_word(19'h6789A, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_word(19'h3FFFF, Q_ONE, Q_ONE, Q_MIN, Q_MIN);
		send_word(19'h00001, 16'sd1, 16'sd0, 16'sd0, -16'sd1);
		// S, S-dagger, T, T-dagger and the extreme phase
		apply_setting(TARGET_W'(3), GATE_PHASE, 16'sd0, Q_ONE);
		send_word(19'h7FFF0, Q_ONE, Q_MIN, Q_MIN, Q_ONE);
		send_word(19'h0000F, 16'sd3, 16'sd5, -16'sd3, 16'sd1);
		apply_setting(TARGET_W'(3), GATE_PHASE, 16'sd0, -Q_ONE);
		send_word(19'h1F0F0, 16'sd3, 16'sd5, Q_MIN, 16'sd1);
		apply_setting(TARGET_W'(3), GATE_PHASE, Q_T, Q_T);
		send_word(19'h1F0F0, 16'sd3, 16'sd5, 16'sd1234, -16'sd4321);
		apply_setting(TARGET_W'(3), GATE_PHASE, Q_T, -Q_T);
		send_word(19'h0F0F0, 16'sd3, 16'sd5, Q_ONE, Q_MIN);
		apply_setting('0, GATE_PHASE, Q_MIN, Q_MIN);
		send_word('1, 16'sd0, 16'sd0, Q_MIN, Q_MIN);
		// spare codes behave as identity
		apply_setting(TARGET_W'(NQ - 1), GATE_SPARE_A, Q_MIN, Q_ONE);
		send_word(19'h2468A, Q_MIN, Q_ONE, 16'sd17, -16'sd17);
		apply_setting(TARGET_W'(1), GATE_SPARE_B, Q_ONE, Q_MIN);
		send_word(19'h13579, Q_ONE, Q_MIN, -16'sd17, 16'sd17);

		// random part
		for (int p = 0; p < 12; p++)
			random_phase(p);

		drain();
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
